@@ src/lprt_pkg.sv @@
// Shared types, codes and constants of the route table.
`timescale 1ns / 1ps

package lprt_pkg;

   localparam int ROUTES = 32;
   localparam int IDX_W  = $clog2(ROUTES);
   localparam int CNT_W  = $clog2(ROUTES + 1);
   localparam int SLOT_W = 5;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOOKUP  = 2'd0,
      OP_ADD     = 2'd1,
      OP_DEL_IDX = 2'd2,
      OP_DEL_IF  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_FOUND   = 3'd0,
      ST_NOROUTE = 3'd1,
      ST_UPDATED = 3'd2,
      ST_WRITTEN = 3'd3,
      ST_REFUSED = 3'd4
   } status_type;

   localparam logic [1:0] ORG_CONNECTED = 2'd0;
   localparam logic [1:0] ORG_STATIC    = 2'd1;
   localparam logic [1:0] ORG_DERIVE    = 2'd3;

   // request as classified by the front end
   typedef struct packed {
      op_type           op;
      logic [31:0]      address;
      logic [31:0]      mask;
      logic [31:0]      next_hop;
      logic [7:0]       port;
      logic [1:0]       origin;
      logic [SLOT_W-1:0] slot;
      logic             slot_ok;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [31:0]       hop_out;
      logic [7:0]        port_out;
      logic [SLOT_W-1:0] slot_out;
   } rsp_type;

   function automatic logic [5:0] lead_ones(input logic [31:0] m);
      logic [5:0] n;
      logic       run;
      n   = '0;
      run = 1'b1;
      for (int i = 31; i >= 0; i--) begin
         run = run & m[i];
         n   = n + {5'd0, run};
      end
      return n;
   endfunction

endpackage

@@ src/lprt_front.sv @@
// Front end: takes requests, resolves origin and slot range, queues commands.
`timescale 1ns / 1ps

module lprt_front import lprt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic [1:0]        req_op,
   input  logic [31:0]       req_address,
   input  logic [31:0]       req_mask,
   input  logic [31:0]       req_next_hop,
   input  logic [7:0]        req_port,
   input  logic [1:0]        req_origin,
   input  logic [SLOT_W-1:0] req_slot,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   localparam int PW = $clog2(QDEPTH);

   cmd_type       q_ff [QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   cmd_type       c;
   logic          push, pop;

   always_comb begin
      c.op       = op_type'(req_op);
      c.address  = req_address;
      c.mask     = req_mask;
      c.next_hop = req_next_hop;
      c.port     = req_port;
      c.slot     = req_slot;
      c.slot_ok  = ({{(32-SLOT_W){1'b0}}, req_slot} < 32'(ROUTES));
      if (req_origin == ORG_DERIVE) begin
         c.origin = (req_next_hop == 32'd0) ? ORG_CONNECTED : ORG_STATIC;
      end else begin
         c.origin = req_origin;
      end
   end

   assign req_tready = (cnt_ff != (PW+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PW'((32'(wr_ff) + 1) % QDEPTH) : wr_ff;
      rd_in  = pop  ? PW'((32'(rd_ff) + 1) % QDEPTH) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= c;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QDEPTH)) else $error("queue overfilled");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");

endmodule

@@ src/lprt_back.sv @@
// Back end: scans route memory one entry a cycle bar delete by index; builds the response.
`timescale 1ns / 1ps

module lprt_back import lprt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_EVICT = 5'b00100,
      S_WRITE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // memories: network/mask/hop/port; origin and valid in flops (reset values)
   logic [31:0] net_mem  [ROUTES];
   logic [31:0] mask_mem [ROUTES];
   logic [31:0] hop_mem  [ROUTES];
   logic [7:0]  port_mem [ROUTES];
   logic [1:0]  org_ff   [ROUTES];
   logic [ROUTES-1:0] valid_ff;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // issue counter
   logic        rd_vld_ff;               // registered read data valid
   logic [IDX_W-1:0] rd_idx_ff;
   logic [31:0] rd_net_ff, rd_mask_ff, rd_hop_ff;
   logic [7:0]  rd_port_ff;
   logic        best_vld_ff;
   logic [5:0]  best_len_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0] best_hop_ff;
   logic [7:0]  best_port_ff;
   logic        free_vld_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic        hit_ff;                  // exact match found on add
   logic [IDX_W-1:0] hit_idx_ff;
   logic [IDX_W-1:0] evp_ff;
   logic [IDX_W-1:0] ev_idx_ff;
   logic        wrote_ff;                // add stored its entry
   logic        rsp_vld_ff;
   rsp_type     rsp_ff;

   logic        start, rd_en, scan_end;
   logic [IDX_W-1:0] rd_addr;
   logic        rv, match, exact;
   logic [5:0]  len;
   logic        do_write;
   logic [IDX_W-1:0] wr_idx;

   assign cmd_ready  = (state_ff == S_IDLE);
   assign start      = cmd_valid && cmd_ready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp        = rsp_ff;

   assign rd_en   = (state_ff == S_SCAN) && (cnt_ff < CNT_W'(ROUTES));
   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign scan_end = (state_ff == S_SCAN) && !rd_en && !rd_vld_ff;

   assign rv    = rd_vld_ff && valid_ff[rd_idx_ff];
   assign match = ((cmd_ff.address & rd_mask_ff) == (rd_net_ff & rd_mask_ff));
   assign exact = (rd_net_ff == cmd_ff.address) && (rd_mask_ff == cmd_ff.mask);
   assign len   = lead_ones(rd_mask_ff);

   function automatic logic port_mem_hit(input logic [IDX_W-1:0] idx);
      return valid_ff[idx] && (rd_port_ff == cmd_ff.port);
   endfunction

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               priority case (cmd.op)
                  OP_DEL_IDX: state_in = S_DONE;
                  default:    state_in = S_SCAN;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_en) cnt_in = cnt_ff + 1'b1;
            if (scan_end) begin
               cnt_in = '0;
               if (cmd_ff.op == OP_ADD && !hit_ff && !free_vld_ff) state_in = S_EVICT;
               else if (cmd_ff.op == OP_ADD && !hit_ff)           state_in = S_WRITE;
               else                                                state_in = S_DONE;
            end
         end
         S_EVICT: begin
            cnt_in = cnt_ff + 1'b1;
            if (org_ff[ev_idx_ff] != ORG_CONNECTED) state_in = S_WRITE;
            else if (cnt_ff == CNT_W'(ROUTES - 1))  state_in = S_DONE;
         end
         S_WRITE: state_in = S_DONE;
         S_DONE:  if (!rsp_vld_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign do_write = (state_ff == S_WRITE);
   assign wr_idx   = free_vld_ff ? free_idx_ff : ev_idx_ff;

   always_ff @(posedge clock) begin
      if (start) cmd_ff <= cmd;
      rd_vld_ff <= rd_en;
      rd_idx_ff <= rd_addr;
      if (rd_en) begin
         rd_net_ff  <= net_mem[rd_addr];
         rd_mask_ff <= mask_mem[rd_addr];
         rd_hop_ff  <= hop_mem[rd_addr];
         rd_port_ff <= port_mem[rd_addr];
      end
      if (do_write) begin
         net_mem[wr_idx]  <= cmd_ff.address;
         mask_mem[wr_idx] <= cmd_ff.mask;
      end
      if (do_write) begin
         hop_mem[wr_idx]  <= cmd_ff.next_hop;
         port_mem[wr_idx] <= cmd_ff.port;
      end else if (state_ff == S_SCAN && rv && exact && !hit_ff && cmd_ff.op == OP_ADD) begin
         hop_mem[rd_idx_ff]  <= cmd_ff.next_hop;
         port_mem[rd_idx_ff] <= cmd_ff.port;
      end
      if (rv && match && (!best_vld_ff || len > best_len_ff)) begin
         best_len_ff  <= len;
         best_idx_ff  <= rd_idx_ff;
         best_hop_ff  <= rd_hop_ff;
         best_port_ff <= rd_port_ff;
      end
      if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_vld_ff) free_idx_ff <= rd_idx_ff;
      if (rv && exact && !hit_ff) hit_idx_ff <= rd_idx_ff;
      if (state_ff == S_SCAN) ev_idx_ff <= evp_ff;
      else if (state_ff == S_EVICT && org_ff[ev_idx_ff] == ORG_CONNECTED)
         ev_idx_ff <= IDX_W'((32'(ev_idx_ff) + 1) % ROUTES);
      if (state_ff == S_DONE && (!rsp_vld_ff || rsp_tready)) begin
         rsp_ff.hop_out  <= '0;
         rsp_ff.port_out <= '0;
         rsp_ff.slot_out <= '0;
         unique case (cmd_ff.op)
            OP_LOOKUP: begin
               rsp_ff.status <= best_vld_ff ? ST_FOUND : ST_NOROUTE;
               if (best_vld_ff) begin
                  rsp_ff.hop_out  <= (best_hop_ff == 32'd0) ? cmd_ff.address : best_hop_ff;
                  rsp_ff.port_out <= best_port_ff;
                  rsp_ff.slot_out <= SLOT_W'(best_idx_ff);
               end
            end
            OP_ADD: begin
               if (hit_ff) begin
                  rsp_ff.status   <= ST_UPDATED;
                  rsp_ff.slot_out <= SLOT_W'(hit_idx_ff);
               end else if (free_vld_ff) begin
                  rsp_ff.status   <= ST_WRITTEN;
                  rsp_ff.slot_out <= SLOT_W'(free_idx_ff);
               end else if (wrote_ff) begin
                  rsp_ff.status   <= ST_WRITTEN;
                  rsp_ff.slot_out <= SLOT_W'(ev_idx_ff);
               end else begin
                  rsp_ff.status   <= ST_REFUSED;
               end
            end
            OP_DEL_IDX: begin
               rsp_ff.status   <= ST_FOUND;
               rsp_ff.slot_out <= cmd_ff.slot;
            end
            OP_DEL_IF: rsp_ff.status <= ST_FOUND;
            default:   rsp_ff.status <= ST_FOUND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         valid_ff    <= '0;
         evp_ff      <= '0;
         best_vld_ff <= 1'b0;
         free_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
         wrote_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         for (int i = 0; i < ROUTES; i++) org_ff[i] <= ORG_STATIC;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (start) begin
            best_vld_ff <= 1'b0;
            free_vld_ff <= 1'b0;
            hit_ff      <= 1'b0;
            wrote_ff    <= 1'b0;
         end
         if (state_ff == S_SCAN) begin
            if (rv && match) best_vld_ff <= 1'b1;
            if (rd_vld_ff && !valid_ff[rd_idx_ff]) free_vld_ff <= 1'b1;
            if (rv && exact && cmd_ff.op == OP_ADD && !hit_ff) begin
               hit_ff <= 1'b1;
               org_ff[rd_idx_ff] <= cmd_ff.origin;
            end
            if (rd_vld_ff && cmd_ff.op == OP_DEL_IF && port_mem_hit(rd_idx_ff))
               valid_ff[rd_idx_ff] <= 1'b0;
         end
         if (state_ff == S_EVICT && org_ff[ev_idx_ff] != ORG_CONNECTED)
            evp_ff <= IDX_W'((32'(ev_idx_ff) + 1) % ROUTES);
         if (do_write) begin
            valid_ff[wr_idx] <= 1'b1;
            org_ff[wr_idx]   <= cmd_ff.origin;
            wrote_ff         <= 1'b1;
         end
         if (start && cmd.op == OP_DEL_IDX && cmd.slot_ok)
            valid_ff[IDX_W'(cmd.slot)] <= 1'b0;
         if (state_ff == S_DONE && (!rsp_vld_ff || rsp_tready)) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      do_write |=> valid_ff[$past(wr_idx)]) else $error("written entry not valid");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

endmodule

@@ src/longest_prefix_route_table.sv @@
// Top level of the longest-prefix-match route table.
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req     | in        | req_tvalid/tready  | req_tdata, req_tuser (operation)
// rsp     | out       | rsp_tvalid/tready  | rsp_tdata
// Lookup, add and delete by interface scan all ROUTES entries, one memory read a
// cycle; an add to a full table adds up to ROUTES eviction steps. Delete by
// index skips the scan.
// A two-entry command queue lets requests be taken while a response stalls.
// Synchronous reset clears valid bits and the eviction pointer and sets origins to static.

module longest_prefix_route_table import lprt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // address[31:0], mask[63:32], next_hop[95:64], port[103:96],
   // route_origin[105:104], slot[110:106], zero fill
   input  logic [111:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], hop_out[34:3], port_out[42:35], slot_out[47:43]
   output logic [47:0]  rsp_tdata
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   lprt_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op       (req_tuser),
      .req_address  (req_tdata[31:0]),
      .req_mask     (req_tdata[63:32]),
      .req_next_hop (req_tdata[95:64]),
      .req_port     (req_tdata[103:96]),
      .req_origin   (req_tdata[105:104]),
      .req_slot     (req_tdata[110:106]),
      .cmd_valid, .cmd_ready, .cmd
   );

   lprt_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp
   );

   assign rsp_tdata = {rsp.slot_out, rsp.port_out, rsp.hop_out, rsp.status};

endmodule

@@ dv/longest_prefix_route_table_tb.sv @@
// Testbench for the route table: directed and randomized requests checked against a table model.
`timescale 1ns / 1ps

import lprt_pkg::*;

class route_scoreboard;
   bit          valid_q[ROUTES];
   logic [31:0] net_q[ROUTES];
   logic [31:0] mask_q[ROUTES];
   logic [31:0] hop_q[ROUTES];
   logic [7:0]  port_q[ROUTES];
   logic [1:0]  org_q[ROUTES];
   int          evict_ptr;
   rsp_type     pending[$];
   int          errors;

   function void clear();
      for (int i = 0; i < ROUTES; i++) begin
         valid_q[i] = 0;
         net_q[i] = '0;
         mask_q[i] = '0;
         hop_q[i] = '0;
         port_q[i] = '0;
         org_q[i] = ORG_STATIC;
      end
      evict_ptr = 0;
      pending.delete();
      errors = 0;
   endfunction

   function int prefix_len(logic [31:0] m);
      int n;
      n = 0;
      while (n < 32 && m[31 - n]) n++;
      return n;
   endfunction

   // apply one request to the table copy and queue its response
   function void note_request(op_type op, logic [31:0] addr, logic [31:0] msk,
                              logic [31:0] hop, logic [7:0] prt, logic [1:0] org,
                              logic [4:0] slt);
      rsp_type r;
      int best, best_len, free_idx, c, l;
      r = '{status: ST_FOUND, hop_out: '0, port_out: '0, slot_out: '0};
      case (op)
         OP_LOOKUP: begin
            best = -1;
            best_len = -1;
            for (int i = 0; i < ROUTES; i++)
               if (valid_q[i] && ((addr & mask_q[i]) == (net_q[i] & mask_q[i]))) begin
                  l = prefix_len(mask_q[i]);
                  if (l > best_len) begin
                     best_len = l;
                     best = i;
                  end
               end
            if (best < 0) r.status = ST_NOROUTE;
            else begin
               r.hop_out = (hop_q[best] == 0) ? addr : hop_q[best];
               r.port_out = port_q[best];
               r.slot_out = best[4:0];
            end
         end
         OP_ADD: begin
            free_idx = -1;
            if (org == ORG_DERIVE) org = (hop == 0) ? ORG_CONNECTED : ORG_STATIC;
            for (int i = 0; i < ROUTES; i++) begin
               if (!valid_q[i]) begin
                  if (free_idx < 0) free_idx = i;
               end else if (net_q[i] == addr && mask_q[i] == msk) begin
                  hop_q[i] = hop;
                  port_q[i] = prt;
                  org_q[i] = org;
                  r.status = ST_UPDATED;
                  r.slot_out = i[4:0];
                  pending.push_back(r);
                  return;
               end
            end
            if (free_idx < 0)
               for (int i = 0; i < ROUTES; i++) begin
                  c = (evict_ptr + i) % ROUTES;
                  if (org_q[c] != ORG_CONNECTED) begin
                     free_idx = c;
                     evict_ptr = (c + 1) % ROUTES;
                     break;
                  end
               end
            if (free_idx < 0) r.status = ST_REFUSED;
            else begin
               net_q[free_idx] = addr;
               mask_q[free_idx] = msk;
               hop_q[free_idx] = hop;
               port_q[free_idx] = prt;
               org_q[free_idx] = org;
               valid_q[free_idx] = 1;
               r.status = ST_WRITTEN;
               r.slot_out = free_idx[4:0];
            end
         end
         OP_DEL_IDX: begin
            if (slt < ROUTES) valid_q[slt] = 0;
            r.slot_out = slt;
         end
         default: begin
            for (int i = 0; i < ROUTES; i++)
               if (valid_q[i] && port_q[i] == prt) valid_q[i] = 0;
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_response(logic [47:0] d);
      rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected response %h", d);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (d[2:0] !== e.status) begin
         $error("status expected %0d actual %0d", e.status, d[2:0]);
         errors++;
      end
      if (d[34:3] !== e.hop_out) begin
         $error("hop_out expected %h actual %h", e.hop_out, d[34:3]);
         errors++;
      end
      if (d[42:35] !== e.port_out) begin
         $error("port_out expected %0d actual %0d", e.port_out, d[42:35]);
         errors++;
      end
      if (d[47:43] !== e.slot_out) begin
         $error("slot_out expected %0d actual %0d", e.slot_out, d[47:43]);
         errors++;
      end
   endfunction
endclass

module longest_prefix_route_table_tb;
   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;

   route_scoreboard board;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   int  hold_count;
   int  cycle_count;
   logic [31:0] nets[8];
   logic [31:0] masks[8];

   longest_prefix_route_table i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function logic [31:0] len_mask(int n);
      return (n == 0) ? 32'd0 : ~(32'hFFFF_FFFF >> n);
   endfunction

   // offer one request, with a random gap before it; returns once accepted
   task send_request(op_type op, logic [31:0] addr, logic [31:0] msk, logic [31:0] hop,
                     logic [7:0] prt, logic [1:0] org, logic [4:0] slt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, slt, org, prt, hop, msk, addr};
      // ready is settled mid-cycle; the next rising edge takes the request
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      board.note_request(op, addr, msk, hop, prt, org, slt);
   endtask

   task send_random(bit well_formed);
      int k;
      op_type op;
      logic [31:0] a;
      k = $urandom_range(7);
      op = op_type'($urandom_range(3));
      a = $urandom;
      if (well_formed) begin
         if (op == OP_LOOKUP) a = (nets[k] & masks[k]) | (a & ~masks[k]);
         send_request(op, (op == OP_ADD) ? nets[k] : a, masks[k],
                      ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom),
                      8'($urandom_range(7)), 2'($urandom_range(3)),
                      5'($urandom_range(31)));
      end else
         send_request(op, a, len_mask($urandom_range(32)), 32'($urandom), 8'($urandom),
                      2'($urandom_range(3)), 5'($urandom_range(31)));
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("FAIL longest_prefix_route_table");
         $finish;
      end
   end

   // long receiver hold-off, counted here, while requests keep coming
   initial begin
      hold_off = 0;
      wait (hold_count > 0);
      @(posedge clock);
      hold_off <= 1;
      repeat (hold_count) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      board = new();
      board.clear();
      cycle_count = 0;
      hold_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOOKUP;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty lookup, extremes, ties, derive, full table, refusals
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
      send_request(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'd0, 8'd1, 2'd3, '0);
      send_request(OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 8'hFF, 2'd2, '1);
      send_request(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 8'd0, 2'd1, '0);
      send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd3, 2'd0, '0);
      send_request(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0, '0, '0);
      send_request(OP_LOOKUP, 32'h0A02_0203, '0, '0, '0, '0, '0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
      send_request(OP_LOOKUP, 32'h5555_AAAA, '0, '0, '0, '0, '0);
      send_request(OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'd7, 8'd9, 2'd3, '0);
      send_request(OP_DEL_IDX, '0, '0, '0, '0, '0, 5'd1);
      send_request(OP_DEL_IDX, '0, '0, '0, '0, '0, 5'd31);
      send_request(OP_DEL_IF, '0, '0, '0, 8'hFF, '0, '0);
      send_request(OP_DEL_IF, '0, '0, '0, 8'd0, '0, '0);
      send_request(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0, '0, '0);
      for (int i = 0; i < ROUTES + 3; i++)
         send_request(OP_ADD, {i[7:0], 24'h0}, 32'hFF00_0000, i[0] ? 32'd0 : 32'hC0A8_0001,
                      8'd20, i[0] ? 2'd3 : 2'd2, '0);
      for (int i = 0; i < ROUTES + 2; i++)
         send_request(OP_ADD, {8'hE0, i[7:0], 16'h0}, 32'hFFFF_0000, 32'd0, 8'd21, 2'd0, '0);
      send_request(OP_DEL_IF, '0, '0, '0, 8'd20, '0, '0);
      send_request(OP_DEL_IF, '0, '0, '0, 8'd21, '0, '0);

      for (int k = 0; k < 8; k++) begin
         masks[k] = len_mask($urandom_range(32));
         nets[k] = $urandom & masks[k];
      end
      masks[0] = '0;
      masks[1] = '1;

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 56) : 0;
         recv_idle_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 56) : 0;
         if (ph == 0) hold_count = 400;
         for (int n = 0; n < 125; n++) send_random($urandom_range(9) < 8);
         if (ph == 0) for (int n = 0; n < 50; n++) send_random(1);
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) $display("PASS longest_prefix_route_table");
      else $display("FAIL longest_prefix_route_table");
      $finish;
   end
endmodule

@@ files.f @@
src/lprt_pkg.sv
src/lprt_front.sv
src/lprt_back.sv
src/longest_prefix_route_table.sv
dv/longest_prefix_route_table_tb.sv
